/* sv/imptt_pkg.sv */
// Package for the indexed max-priority task table.
// Holds field widths, request and status codes, controller states and the
// command/status structs shared by the controller, datapath and top level.
package imptt_pkg;

  // Field widths of one request and one result word.
  localparam int unsigned ReqW    = 2;
  localparam int unsigned KeyW    = 16;
  localparam int unsigned OwnerW  = 16;
  localparam int unsigned PrioW   = 32;
  localparam int unsigned StatusW = 2;

  // Default table depth.
  localparam int unsigned DefEntries = 64;

  // Request kinds.
  typedef enum logic [ReqW-1:0] {
    REQ_ADD    = 2'd0,
    REQ_EDIT   = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_EXEC   = 2'd3
  } req_e;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  // Controller states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_e;

  // One table entry as stored in the memory.
  typedef struct packed {
    logic              valid;
    logic [KeyW-1:0]   task_key;
    logic [OwnerW-1:0] owner;
    logic [PrioW-1:0]  prio;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;  // latch the request word and reset the scan trackers
    logic clear_wr;  // write an empty entry at the sweep address
    logic scan_rd;   // read the entry at the sweep address
    logic commit;    // update the table and load the result word
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_last;  // sweep address is at the last entry
    logic out_free;  // result register can take a new word this cycle
  } dp_status_t;

endpackage

/* sv/indexed_max_priority_task_table.sv */
// Top level of the indexed max-priority task table.
// Instantiates imptt_ctrl and imptt_dp; depends on imptt_pkg.
//
// Usage:
//   The request channel (in_valid_i/in_ready_o) carries one word per
//   request: req_type_i selects add, edit priority, remove or execute top,
//   with task_key_i, owner_i and prio_i as operands. The result channel
//   (out_valid_o/out_ready_i) returns exactly one word per request:
//   status_o and top_owner_o (the executed task's user on a good execute,
//   zero otherwise).
//   Each request scans the entry memory once through its single read port,
//   one entry per cycle, and a new request is taken only after the
//   previous one has committed its result.
//   After reset the block sweeps the memory to mark every entry empty;
//   in_ready_o stays low during the sweep.
//   The result register holds its word while the receiver stalls; the next
//   request is still taken and scanned, and only its commit waits until the
//   register is free.
module indexed_max_priority_task_table #(
  parameter int unsigned ENTRIES = imptt_pkg::DefEntries
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [imptt_pkg::ReqW-1:0]    req_type_i,
  input  logic [imptt_pkg::KeyW-1:0]    task_key_i,
  input  logic [imptt_pkg::OwnerW-1:0]  owner_i,
  input  logic [imptt_pkg::PrioW-1:0]   prio_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [imptt_pkg::StatusW-1:0] status_o,
  output logic [imptt_pkg::OwnerW-1:0]  top_owner_o
);
  import imptt_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  // Sequencer for clearing, scanning and commit.
  imptt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .dp_status_i (dp_status),
    .cmd_o       (cmd)
  );

  // Entry memory, scan trackers and result register.
  imptt_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (dp_status),
    .req_type_i   (req_type_i),
    .task_key_i   (task_key_i),
    .owner_i      (owner_i),
    .prio_i       (prio_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .out_status_o (status_o),
    .out_owner_o  (top_owner_o)
  );

  // A taken request leaves idle, so no second word is taken right after.
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request taken twice in a row");

  // Commit never overwrites a result word that is still waiting.
  a_commit_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!out_valid_o || out_ready_i))
    else $error("commit while result register is stalled");

  // A new result word only appears after a commit.
  a_result_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.commit))
    else $error("result valid without commit");

  // Only a good execute reports a nonzero owner.
  a_owner_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != STAT_OK) |-> (top_owner_o == '0))
    else $error("owner nonzero on failed request");

endmodule

/* sv/imptt_ctrl.sv */
// Controller of the task table: clearing sweep, scan sequencing and commit.
// Depends on imptt_pkg for state, command and status types.
module imptt_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  imptt_pkg::dp_status_t dp_status_i,
  output imptt_pkg::ctrl_cmd_t  cmd_o
);
  import imptt_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (dp_status_i.cnt_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (dp_status_i.cnt_last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        if (dp_status_i.out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  // Output decode.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
      end
      S_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.load_req = in_valid_i;
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
      end
      S_DRAIN: begin
        cmd_o = '0;
      end
      S_COMMIT: begin
        cmd_o.commit = dp_status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

/* sv/imptt_dp.sv */
// Datapath of the task table: entry memory, sweep counter, scan trackers
// for key match, first free slot and top task, and the result register.
// Depends on imptt_pkg for entry, command and status types.
module imptt_dp #(
  parameter int unsigned ENTRIES = imptt_pkg::DefEntries
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  imptt_pkg::ctrl_cmd_t                cmd_i,
  output imptt_pkg::dp_status_t               status_o,
  input  logic [imptt_pkg::ReqW-1:0]          req_type_i,
  input  logic [imptt_pkg::KeyW-1:0]          task_key_i,
  input  logic [imptt_pkg::OwnerW-1:0]        owner_i,
  input  logic [imptt_pkg::PrioW-1:0]         prio_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [imptt_pkg::StatusW-1:0]       out_status_o,
  output logic [imptt_pkg::OwnerW-1:0]        out_owner_o
);
  import imptt_pkg::*;

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);

  // Entry memory, one write and one registered read port.
  entry_t mem [ENTRIES];
  entry_t rd_q;
  logic   rd_en_q;
  logic [IdxW-1:0] rd_idx_q;

  // Sweep address shared by clearing and scanning.
  logic [IdxW-1:0] cnt_q, cnt_d;

  // Latched request word.
  req_e              req_q;
  logic [KeyW-1:0]   key_q;
  logic [OwnerW-1:0] own_q;
  logic [PrioW-1:0]  prio_q;

  // Scan trackers.
  logic              found_q, found_d;
  logic [IdxW-1:0]   found_idx_q, found_idx_d;
  logic [OwnerW-1:0] found_owner_q, found_owner_d;
  logic              free_q, free_d;
  logic [IdxW-1:0]   free_idx_q, free_idx_d;
  logic              best_q, best_d;
  logic [IdxW-1:0]   best_idx_q, best_idx_d;
  logic [KeyW-1:0]   best_key_q, best_key_d;
  logic [OwnerW-1:0] best_owner_q, best_owner_d;
  logic [PrioW-1:0]  best_prio_q, best_prio_d;

  // Commit outcome.
  logic              wr_en;
  logic [IdxW-1:0]   wr_addr;
  entry_t            wr_data;
  status_e           res_status;
  logic [OwnerW-1:0] res_owner;

  // Result register.
  logic              out_valid_q, out_valid_d;
  logic [StatusW-1:0] out_status_q;
  logic [OwnerW-1:0]  out_owner_q;

  assign status_o = '{cnt_last: (cnt_q == LastIdx), out_free: (!out_valid_q || out_ready_i)};

  // Sweep counter wraps to zero after the last entry.
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.clear_wr || cmd_i.scan_rd) begin
      cnt_d = (cnt_q == LastIdx) ? '0 : cnt_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      rd_en_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      rd_en_q <= cmd_i.scan_rd;
    end
  end

  // Memory write port: clearing sweep or commit update.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_wr) begin
      mem[cnt_q] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Memory read port with registered data.
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_rd) begin
      rd_q     <= mem[cnt_q];
      rd_idx_q <= cnt_q;
    end
  end

  // Request word capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q  <= req_e'(req_type_i);
      key_q  <= task_key_i;
      own_q  <= owner_i;
      prio_q <= prio_i;
    end
  end

  // Tracker update for the entry read in the previous cycle.
  always_comb begin
    found_d       = found_q;
    found_idx_d   = found_idx_q;
    found_owner_d = found_owner_q;
    free_d        = free_q;
    free_idx_d    = free_idx_q;
    best_d        = best_q;
    best_idx_d    = best_idx_q;
    best_key_d    = best_key_q;
    best_owner_d  = best_owner_q;
    best_prio_d   = best_prio_q;
    if (cmd_i.load_req) begin
      found_d = 1'b0;
      free_d  = 1'b0;
      best_d  = 1'b0;
    end else if (rd_en_q) begin
      if (rd_q.valid && rd_q.task_key == key_q && !found_q) begin
        found_d       = 1'b1;
        found_idx_d   = rd_idx_q;
        found_owner_d = rd_q.owner;
      end
      if (!rd_q.valid && !free_q) begin
        free_d     = 1'b1;
        free_idx_d = rd_idx_q;
      end
      // Higher priority wins; equal priority goes to the higher task id.
      if (rd_q.valid && (!best_q || rd_q.prio > best_prio_q ||
          (rd_q.prio == best_prio_q && rd_q.task_key > best_key_q))) begin
        best_d       = 1'b1;
        best_idx_d   = rd_idx_q;
        best_key_d   = rd_q.task_key;
        best_owner_d = rd_q.owner;
        best_prio_d  = rd_q.prio;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      free_q  <= 1'b0;
      best_q  <= 1'b0;
    end else begin
      found_q <= found_d;
      free_q  <= free_d;
      best_q  <= best_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_idx_q   <= found_idx_d;
    found_owner_q <= found_owner_d;
    free_idx_q    <= free_idx_d;
    best_idx_q    <= best_idx_d;
    best_key_q    <= best_key_d;
    best_owner_q  <= best_owner_d;
    best_prio_q   <= best_prio_d;
  end

  // Table update and result for the finished scan.
  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = found_idx_q;
    wr_data    = '0;
    res_status = STAT_OK;
    res_owner  = '0;
    case (req_q)
      REQ_ADD: begin
        wr_data = '{valid: 1'b1, task_key: key_q, owner: own_q, prio: prio_q};
        if (found_q) begin
          wr_en = cmd_i.commit;
        end else if (free_q) begin
          wr_en   = cmd_i.commit;
          wr_addr = free_idx_q;
        end else begin
          res_status = STAT_FULL;
        end
      end
      REQ_EDIT: begin
        wr_data = '{valid: 1'b1, task_key: key_q, owner: found_owner_q, prio: prio_q};
        if (found_q) begin
          wr_en = cmd_i.commit;
        end else begin
          res_status = STAT_NOT_FOUND;
        end
      end
      REQ_REMOVE: begin
        if (found_q) begin
          wr_en = cmd_i.commit;
        end else begin
          res_status = STAT_NOT_FOUND;
        end
      end
      default: begin
        wr_addr = best_idx_q;
        if (best_q) begin
          wr_en     = cmd_i.commit;
          res_owner = best_owner_q;
        end else begin
          res_status = STAT_EMPTY;
        end
      end
    endcase
  end

  // Result register: holds the word until the receiver takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_status_q <= res_status;
      out_owner_q  <= res_owner;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_owner_o  = out_owner_q;

endmodule

/* tb/imptt_checker.sv */
// Scoreboard for the indexed max-priority task table: watches both channels,
// keeps its own copy of the task table and checks every result word.
// Depends on imptt_pkg for field widths and the request and status codes.
module imptt_checker #(
  parameter int unsigned ENTRIES = imptt_pkg::DefEntries
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [imptt_pkg::ReqW-1:0]    req_type_i,
  input  logic [imptt_pkg::KeyW-1:0]    task_key_i,
  input  logic [imptt_pkg::OwnerW-1:0]  owner_i,
  input  logic [imptt_pkg::PrioW-1:0]   prio_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [imptt_pkg::StatusW-1:0] status_i,
  input  logic [imptt_pkg::OwnerW-1:0]  top_owner_i,
  output int                            fail_count_o,
  output int                            outstanding_o,
  output int                            checked_o,
  output int                            served_o,
  output int                            empty_seen_o,
  output int                            missing_seen_o,
  output int                            full_seen_o
);
  import imptt_pkg::*;

  // Only the first 40 mismatches are printed; all of them are counted.
  localparam int PrintCap = 40;

  // One expected result word, with a mark for an execute that took a task.
  typedef struct packed {
    status_e           status;
    logic [OwnerW-1:0] owner;
    logic              exec_hit;
  } reply_t;

  // Shadow copy of the task table.
  logic              tbl_valid [ENTRIES];
  logic [KeyW-1:0]   tbl_key   [ENTRIES];
  logic [OwnerW-1:0] tbl_owner [ENTRIES];
  logic [PrioW-1:0]  tbl_prio  [ENTRIES];

  // Result words still owed by the block, oldest first.
  reply_t due_replies [$];
  reply_t want;
  int     n;

  // Report one mismatch and count it.
  task automatic flag(string msg);
    fail_count_o++;
    if (fail_count_o <= PrintCap) begin
      $display("[%0t] MISMATCH: %s", $time, msg);
    end
  endtask

  // Apply one request to the shadow table and return the word it must produce.
  function automatic reply_t apply_request(req_e kind, logic [KeyW-1:0] key,
                                           logic [OwnerW-1:0] own,
                                           logic [PrioW-1:0] pr);
    reply_t r;
    int     i;
    int     hit;
    int     spot;
    int     best;
    r.status   = STAT_OK;
    r.owner    = '0;
    r.exec_hit = 1'b0;
    hit  = -1;
    spot = -1;
    best = -1;
    // One pass finds the matching slot, the lowest free slot and the top task.
    for (i = 0; i < ENTRIES; i++) begin
      if (tbl_valid[i]) begin
        if (hit < 0 && tbl_key[i] == key) begin
          hit = i;
        end
        if (best < 0 || tbl_prio[i] > tbl_prio[best] ||
            (tbl_prio[i] == tbl_prio[best] && tbl_key[i] > tbl_key[best])) begin
          best = i;
        end
      end else if (spot < 0) begin
        spot = i;
      end
    end
    case (kind)
      REQ_ADD: begin
        // A present id is overwritten in place; a new id takes the lowest free slot.
        if (hit < 0) begin
          hit = spot;
        end
        if (hit < 0) begin
          r.status = STAT_FULL;
        end else begin
          tbl_valid[hit] = 1'b1;
          tbl_key[hit]   = key;
          tbl_owner[hit] = own;
          tbl_prio[hit]  = pr;
        end
      end
      REQ_EDIT: begin
        if (hit < 0) begin
          r.status = STAT_NOT_FOUND;
        end else begin
          tbl_prio[hit] = pr;
        end
      end
      REQ_REMOVE: begin
        if (hit < 0) begin
          r.status = STAT_NOT_FOUND;
        end else begin
          tbl_valid[hit] = 1'b0;
        end
      end
      default: begin
        if (best < 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.owner         = tbl_owner[best];
          r.exec_hit      = 1'b1;
          tbl_valid[best] = 1'b0;
        end
      end
    endcase
    return r;
  endfunction

  // Results are checked before a new request is applied in the same cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (n = 0; n < ENTRIES; n++) begin
        tbl_valid[n] = 1'b0;
      end
      due_replies.delete();
      fail_count_o   = 0;
      checked_o      = 0;
      served_o       = 0;
      empty_seen_o   = 0;
      missing_seen_o = 0;
      full_seen_o    = 0;
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (due_replies.size() == 0) begin
          flag($sformatf("result word with none expected: status %0d owner %h",
                         status_i, top_owner_i));
        end else begin
          want = due_replies.pop_front();
          checked_o++;
          if (status_i !== want.status) begin
            flag($sformatf("word %0d: status %0d, expected %0d",
                           checked_o, status_i, want.status));
          end
          if (top_owner_i !== want.owner) begin
            flag($sformatf("word %0d: top_owner %h, expected %h",
                           checked_o, top_owner_i, want.owner));
          end
          case (want.status)
            STAT_OK:    if (want.exec_hit) served_o++;
            STAT_EMPTY: empty_seen_o++;
            STAT_FULL:  full_seen_o++;
            default:    missing_seen_o++;
          endcase
        end
      end
      if (in_valid_i && in_ready_i) begin
        due_replies = {due_replies, apply_request(req_e'(req_type_i), task_key_i,
                                                  owner_i, prio_i)};
      end
      outstanding_o <= due_replies.size();
    end
  end

endmodule

/* tb/tb_top.sv */
// Top of the testbench for indexed_max_priority_task_table: clock, reset,
// request stimulus, result-side stalls and the verdict.
// Depends on imptt_pkg, the block itself and imptt_checker.
module tb_top;
  import imptt_pkg::*;

  localparam int unsigned Entries     = DefEntries;
  localparam int          RandomWords = 600;
  localparam int          DrainCycles = 2 * Entries + 8;
  localparam int          LimitCycles = 600000;

  // Traffic mixes of the random phases.
  localparam int MixFill  = 0;
  localparam int MixDrain = 1;
  localparam int MixBlend = 2;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid;
  logic              in_ready;
  logic [ReqW-1:0]   req_type;
  logic [KeyW-1:0]   task_key;
  logic [OwnerW-1:0] owner;
  logic [PrioW-1:0]  prio;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [StatusW-1:0] status;
  logic [OwnerW-1:0] top_owner;

  int fail_count;
  int outstanding;
  int checked;
  int served;
  int empty_seen;
  int missing_seen;
  int full_seen;

  // Stimulus bookkeeping.
  logic [KeyW-1:0] known_keys [$];
  int burst_left = 0;
  int words_sent = 0;
  int sink_left  = 0;
  int sink_mode  = 0;

  indexed_max_priority_task_table #(.ENTRIES(Entries)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .req_type_i  (req_type),
    .task_key_i  (task_key),
    .owner_i     (owner),
    .prio_i      (prio),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .status_o    (status),
    .top_owner_o (top_owner)
  );

  imptt_checker #(.ENTRIES(Entries)) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .req_type_i     (req_type),
    .task_key_i     (task_key),
    .owner_i        (owner),
    .prio_i         (prio),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .status_i       (status),
    .top_owner_i    (top_owner),
    .fail_count_o   (fail_count),
    .outstanding_o  (outstanding),
    .checked_o      (checked),
    .served_o       (served),
    .empty_seen_o   (empty_seen),
    .missing_seen_o (missing_seen),
    .full_seen_o    (full_seen)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Result side: stretches of always-ready, random stalls and long stalls.
  always @(posedge clk_i) begin
    if (sink_left == 0) begin
      sink_mode <= $urandom_range(0, 2);
      sink_left <= $urandom_range(50, 400);
    end else begin
      sink_left <= sink_left - 1;
    end
    case (sink_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 1) == 1);
      default: out_ready <= ($urandom_range(0, 39) == 0);
    endcase
  end

  // Hard stop in case the block hangs.
  initial begin
    repeat (LimitCycles) @(posedge clk_i);
    $display("Timeout after %0d cycles with %0d words outstanding", LimitCycles, outstanding);
    $display("indexed_max_priority_task_table test failed");
    $finish;
  end

  // Priority: often a narrow range to force ties, sometimes the extremes, else fully random.
  function automatic logic [PrioW-1:0] rand_prio();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      return $urandom_range(0, 7);
    end else if (roll < 50) begin
      return ($urandom_range(0, 1) == 1) ? '1 : '0;
    end
    return $urandom();
  endfunction

  // Task id: a fresh random id, a small id, or one that was added before.
  function automatic logic [KeyW-1:0] pick_key(int fresh_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < fresh_pct || known_keys.size() == 0) begin
      return KeyW'($urandom_range(0, 65535));
    end else if (roll < fresh_pct + (100 - fresh_pct) / 3) begin
      return KeyW'($urandom_range(0, 15));
    end
    return known_keys[$urandom_range(0, known_keys.size() - 1)];
  endfunction

  // Send one request word and wait for its handshake; idle between bursts.
  task automatic push_request(req_e kind, logic [KeyW-1:0] key,
                              logic [OwnerW-1:0] own, logic [PrioW-1:0] pr);
    int gap;
    in_valid <= 1'b1;
    req_type <= kind;
    task_key <= key;
    owner    <= own;
    prio     <= pr;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    words_sent++;
    if (kind == REQ_ADD) begin
      known_keys = {known_keys, key};
      if (known_keys.size() > 96) begin
        void'(known_keys.pop_front());
      end
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Stimulus and verdict.
  initial begin
    int rand_sent;
    int phase;
    int mix;
    int span;
    int roll;
    rst_ni   = 1'b0;
    in_valid = 1'b0;
    req_type = '0;
    task_key = '0;
    owner    = '0;
    prio     = '0;
    rand_sent = 0;
    phase     = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: empty table, absent ids, extremes, replace and ties.
    push_request(REQ_EXEC, KeyW'($urandom()), OwnerW'($urandom()), $urandom());
    push_request(REQ_EDIT, 16'h1234, OwnerW'($urandom()), 32'h5);
    push_request(REQ_REMOVE, 16'hffff, OwnerW'($urandom()), $urandom());
    push_request(REQ_ADD, 16'h0000, 16'h0000, 32'h0000_0000);
    push_request(REQ_ADD, 16'hffff, 16'hffff, 32'hffff_ffff);
    push_request(REQ_ADD, 16'h0100, 16'haaaa, 32'hffff_ffff);
    push_request(REQ_ADD, 16'h0100, 16'h5555, 32'h0000_0007);
    push_request(REQ_EDIT, 16'h0100, OwnerW'($urandom()), 32'hffff_ffff);
    push_request(REQ_EXEC, KeyW'($urandom()), OwnerW'($urandom()), $urandom());
    push_request(REQ_EXEC, KeyW'($urandom()), OwnerW'($urandom()), $urandom());
    push_request(REQ_REMOVE, 16'h0000, OwnerW'($urandom()), $urandom());
    push_request(REQ_REMOVE, 16'h0000, OwnerW'($urandom()), $urandom());
    push_request(REQ_EXEC, KeyW'($urandom()), OwnerW'($urandom()), $urandom());
    push_request(REQ_ADD, 16'h0005, 16'h0001, 32'd10);
    push_request(REQ_ADD, 16'h0006, 16'h0002, 32'd10);
    push_request(REQ_EDIT, 16'h0005, OwnerW'($urandom()), 32'd11);
    push_request(REQ_EDIT, 16'h0007, OwnerW'($urandom()), 32'd12);
    push_request(REQ_EXEC, KeyW'($urandom()), OwnerW'($urandom()), $urandom());
    push_request(REQ_EXEC, KeyW'($urandom()), OwnerW'($urandom()), $urandom());
    push_request(REQ_EXEC, KeyW'($urandom()), OwnerW'($urandom()), $urandom());

    // Random phases; the first one fills the table well past full.
    while (rand_sent < RandomWords) begin
      mix  = (phase == 0) ? MixFill : $urandom_range(0, 2);
      span = (phase == 0) ? 200 : $urandom_range(40, 150);
      if (span > RandomWords - rand_sent) begin
        span = RandomWords - rand_sent;
      end
      repeat (span) begin
        roll = $urandom_range(0, 99);
        if (mix == MixDrain) begin
          roll = (roll < 20) ? 0 : (roll < 30) ? 80 : (roll < 45) ? 88 : 99;
        end else if (mix == MixBlend) begin
          roll = (roll < 25) ? 0 : (roll < 50) ? 80 : (roll < 75) ? 88 : 99;
        end
        if (roll < 75) begin
          push_request(REQ_ADD, pick_key((mix == MixFill) ? 80 : 40),
                       OwnerW'($urandom_range(0, 65535)), rand_prio());
        end else if (roll < 85) begin
          push_request(REQ_EDIT, pick_key(10), OwnerW'($urandom()), rand_prio());
        end else if (roll < 92) begin
          push_request(REQ_REMOVE, pick_key(10), OwnerW'($urandom()), $urandom());
        end else begin
          push_request(REQ_EXEC, KeyW'($urandom()), OwnerW'($urandom()), $urandom());
        end
        rand_sent++;
      end
      phase++;
    end

    // Wait for every owed word, then for stray extra ones.
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d requests in %0d random phases; %0d result words checked.",
             words_sent, phase, checked);
    $display("Executes served %0d, empty %0d, not found %0d, table full %0d.",
             served, empty_seen, missing_seen, full_seen);
    if (fail_count == 0) begin
      $display("indexed_max_priority_task_table test passed");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("indexed_max_priority_task_table test failed");
    end
    $finish;
  end

endmodule

/* files.f */
sv/imptt_pkg.sv
sv/imptt_ctrl.sv
sv/imptt_dp.sv
sv/indexed_max_priority_task_table.sv
tb/imptt_checker.sv
tb/tb_top.sv
